// ----- hdl/pta_pkg.sv -----
// Shared codes and types of the power-of-two block allocator.
package pta_pkg;

    localparam int LG_W = 4;

    typedef logic [2:0] status_t;

    localparam status_t ST_OK      = 3'd0;
    localparam status_t ST_ZERO    = 3'd1;
    localparam status_t ST_LARGE   = 3'd2;
    localparam status_t ST_NOMEM   = 3'd3;
    localparam status_t ST_RANGE   = 3'd4;
    localparam status_t ST_ALIGN   = 3'd5;
    localparam status_t ST_NOPAGE  = 3'd6;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic REG_BASE  = 1'b0;
    localparam logic REG_PAGES = 1'b1;

    typedef struct packed {
        status_t     status;
        logic [31:0] granted_address;
        logic [11:0] class_bytes;
        logic        page_fetched;
        logic        page_released;
        logic [5:0]  page_number;
    } result_t;

endpackage

// ----- hdl/pta_ram.sv -----
// Simple dual-port RAM, one write and one registered read per cycle.
module pta_ram #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 1,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/power_of_two_block_allocator_unit.sv -----
// Top level of the power-of-two block allocator: sequencer, list state and link stores.
//
// Usage: a request is taken when start is high and busy is low. command 0 allocates
// request_size bytes, command 1 frees the block at free_address. Exactly one result
// comes back per request, on the result ports for one cycle with done high; the
// receiver cannot stall, so it must take it in that cycle.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 region base, 1 page count)
// and cfg_data; cfg_ready is always high. Any write restarts the allocator: all
// pages free in ascending order, all class lists empty. Write only while idle.
// States from accept to done, all ending in S_DONE: an error found at once, S_CHK;
// an allocate from a list, S_CHK, S_RM1, S_RM2; one that splits a page, S_CHK,
// S_SP0, S_SP1, S_SPL (one slot of the page marked per cycle, block starts linked
// as they pass), S_RM1, S_RM2; a free without page release, or rejected as not
// allocated, S_CHK, S_FR1, S_FR2; one that releases a page adds S_WK1, S_WK2
// per entry of the class list walked, then S_REL. One request at a time; busy is high
// from accept until done; the next request can be taken in the cycle after done.
// Reset: asynchronous, active low; same state as a restart with zero pages.
// A split writes the listed flag of every slot in its page, so flags left from
// before a restart are never read; page info and free-page links have valid bits.
module power_of_two_block_allocator_unit
    import pta_pkg::*;
#(
    parameter int PAGE_BYTES    = 4096,
    parameter int LOG2_SMALLEST = 3,
    parameter int LOG2_LARGEST  = 11,
    parameter int MAX_PAGES     = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        command,
    input  logic [11:0] request_size,
    input  logic [31:0] free_address,
    output logic        done,
    output logic [2:0]  status,
    output logic [31:0] granted_address,
    output logic [11:0] class_bytes,
    output logic        page_fetched,
    output logic        page_released,
    output logic [5:0]  page_number,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int LOG2_PAGE = $clog2(PAGE_BYTES);
    localparam int NCLS      = LOG2_LARGEST - LOG2_SMALLEST + 1;
    localparam int CLS_W     = (NCLS > 1) ? $clog2(NCLS) : 1;
    localparam int SPP_LOG   = LOG2_PAGE - LOG2_SMALLEST;
    localparam int SPP       = 1 << SPP_LOG;
    localparam int PG_W      = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int NSLOT     = MAX_PAGES * SPP;
    localparam int SL_W      = (NSLOT > 1) ? $clog2(NSLOT) : 1;
    localparam int NP_W      = $clog2(MAX_PAGES + 1);
    localparam int FB_W      = $clog2(SPP + 1);
    localparam int PGE_W     = LG_W + FB_W;

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_CHK  = 13'b0000000000010,
        S_RM1  = 13'b0000000000100,
        S_RM2  = 13'b0000000001000,
        S_SP0  = 13'b0000000010000,
        S_SP1  = 13'b0000000100000,
        S_SPL  = 13'b0000001000000,
        S_FR1  = 13'b0000010000000,
        S_FR2  = 13'b0000100000000,
        S_WK1  = 13'b0001000000000,
        S_WK2  = 13'b0010000000000,
        S_REL  = 13'b0100000000000,
        S_DONE = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration and free-page list
    logic [31:0]     base_reg, base_next;
    logic [NP_W-1:0] pages_n_reg, pages_n_next;
    logic [PG_W-1:0] fp_head_reg, fp_head_next;
    logic [PG_W-1:0] fp_tail_reg, fp_tail_next;
    logic            pages_ne_reg, pages_ne_next;
    logic            fp_last_reg, fp_last_next;

    // class lists
    logic [SL_W-1:0] head_reg [NCLS];
    logic [SL_W-1:0] head_next [NCLS];
    logic [SL_W-1:0] tail_reg [NCLS];
    logic [SL_W-1:0] tail_next [NCLS];
    logic [NCLS-1:0] ne_reg, ne_next;

    // valid bits for page info and free-page links
    logic [MAX_PAGES-1:0] pg_vld_reg;
    logic [MAX_PAGES-1:0] fpn_vld_reg;
    logic                 pg_vq_reg;
    logic                 fpn_vq_reg;
    logic [PG_W-1:0]      fpn_aq_reg;

    // request and working registers
    logic            cmd_reg, cmd_next;
    logic [11:0]     size_reg, size_next;
    logic [31:0]     addr_reg, addr_next;
    logic [LG_W-1:0] lg_reg, lg_next;
    logic [CLS_W-1:0] cls_reg, cls_next;
    logic [SL_W-1:0] slot_reg, slot_next;
    logic [SL_W-1:0] cur_reg, cur_next;
    logic [SL_W-1:0] pslot_reg, pslot_next;
    logic [SL_W-1:0] step_reg, step_next;
    logic [PG_W-1:0] page_reg, page_next;
    logic            pf_reg, pf_next;
    result_t         res_reg, res_next;

    // memory ports
    logic             nxt_we, prv_we, lst_we, pg_we, fpn_we;
    logic [SL_W-1:0]  nxt_wa, nxt_wd, nxt_ra, nxt_rd;
    logic [SL_W-1:0]  prv_wa, prv_wd, prv_ra, prv_rd;
    logic [SL_W-1:0]  lst_wa, lst_ra;
    logic             lst_wd, lst_rd;
    logic [PG_W-1:0]  pg_wa, pg_ra;
    logic [PGE_W-1:0] pg_wd, pg_rd;
    logic [PG_W-1:0]  fpn_wa, fpn_wd, fpn_ra, fpn_rd;

    // decode helpers
    logic [LG_W-1:0]  lg_calc;
    logic [CLS_W-1:0] c_calc;
    logic             too_large;
    logic             k_found;
    logic [CLS_W-1:0] k_sel;
    logic [31:0]      off;
    logic             off_range;
    logic             off_align;
    logic [LG_W-1:0]  pg_lg;
    logic [FB_W-1:0]  pg_cnt;
    logic [FB_W-1:0]  nb_calc;
    logic [FB_W-1:0]  nb_fr;
    logic [FB_W-1:0]  cnt_inc;
    logic [PG_W-1:0]  fpn_dflt;
    logic [PG_W-1:0]  fpn_val;
    logic [SL_W-1:0]  pbase;
    logic             blk_start;
    logic             cfg_wr;
    logic [NP_W-1:0]  np_new;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign busy      = (state_reg != S_IDLE);
    assign done      = (state_reg == S_DONE);

    assign status          = res_reg.status;
    assign granted_address = res_reg.granted_address;
    assign class_bytes     = res_reg.class_bytes;
    assign page_fetched    = res_reg.page_fetched;
    assign page_released   = res_reg.page_released;
    assign page_number     = res_reg.page_number;

    // size class of the request
    always_comb
    begin
        lg_calc = LG_W'(LOG2_SMALLEST);
        for (int j = 0; j < 12; j++)
        begin
            if (((13'd1 << j) < {1'b0, size_reg}) && (j + 1 > LOG2_SMALLEST))
            begin
                lg_calc = LG_W'(j + 1);
            end
        end
    end

    assign c_calc    = CLS_W'(lg_calc - LG_W'(LOG2_SMALLEST));
    assign too_large = 32'(size_reg) > (32'd1 << LOG2_LARGEST);
    assign nb_calc   = FB_W'(SPP) >> (lg_calc - LG_W'(LOG2_SMALLEST));

    // first larger class with a free block
    always_comb
    begin
        k_found = 1'b0;
        k_sel   = '0;
        for (int k = 0; k < NCLS; k++)
        begin
            if (!k_found && (32'(c_calc) < k) && ne_reg[k])
            begin
                k_found = 1'b1;
                k_sel   = CLS_W'(k);
            end
        end
    end

    assign off       = addr_reg - base_reg;
    assign off_range = (off >> LOG2_PAGE) >= 32'(pages_n_reg);
    assign off_align = off[LOG2_SMALLEST-1:0] == '0;

    assign pg_lg   = pg_vq_reg ? pg_rd[PGE_W-1 -: LG_W] : '0;
    assign pg_cnt  = pg_vq_reg ? pg_rd[FB_W-1:0] : '0;
    assign nb_fr   = FB_W'(SPP) >> (pg_lg - LG_W'(LOG2_SMALLEST));
    assign cnt_inc = pg_cnt + 1'b1;

    // free-page links default to the ascending chain until written
    assign fpn_dflt = ((32'(fpn_aq_reg) + 32'd1) < 32'(pages_n_reg))
                      ? PG_W'(32'(fpn_aq_reg) + 32'd1) : '0;
    assign fpn_val  = fpn_vq_reg ? fpn_rd : fpn_dflt;
    assign pbase    = SL_W'(page_reg) << SPP_LOG;

    // slot at the start of a block of the class being split
    assign blk_start = (cur_reg & (step_reg - 1'b1)) == '0;

    assign np_new = (cfg_index == REG_PAGES)
                    ? ((32'(cfg_data[6:0]) > MAX_PAGES) ? NP_W'(MAX_PAGES)
                                                       : NP_W'(cfg_data[6:0]))
                    : pages_n_reg;

    always_comb
    begin
        state_next    = state_reg;
        base_next     = base_reg;
        pages_n_next  = pages_n_reg;
        fp_head_next  = fp_head_reg;
        fp_tail_next  = fp_tail_reg;
        pages_ne_next = pages_ne_reg;
        fp_last_next  = fp_last_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        ne_next       = ne_reg;
        cmd_next      = cmd_reg;
        size_next     = size_reg;
        addr_next     = addr_reg;
        lg_next       = lg_reg;
        cls_next      = cls_reg;
        slot_next     = slot_reg;
        cur_next      = cur_reg;
        pslot_next    = pslot_reg;
        step_next     = step_reg;
        page_next     = page_reg;
        pf_next       = pf_reg;
        res_next      = res_reg;

        nxt_we = 1'b0;
        nxt_wa = cur_reg;
        nxt_wd = cur_reg;
        nxt_ra = cur_reg;
        prv_we = 1'b0;
        prv_wa = cur_reg;
        prv_wd = pslot_reg;
        prv_ra = cur_reg;
        lst_we = 1'b0;
        lst_wa = cur_reg;
        lst_wd = 1'b0;
        lst_ra = slot_reg;
        pg_we  = 1'b0;
        pg_wa  = page_reg;
        pg_wd  = '0;
        pg_ra  = page_reg;
        fpn_we = 1'b0;
        fpn_wa = fp_tail_reg;
        fpn_wd = page_reg;
        fpn_ra = page_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = command;
                    size_next  = request_size;
                    addr_next  = free_address;
                    pf_next    = 1'b0;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                res_next   = '0;
                state_next = S_DONE;
                if (cmd_reg == CMD_ALLOC)
                begin
                    if (size_reg == '0)
                    begin
                        res_next.status = ST_ZERO;
                    end
                    else if (too_large)
                    begin
                        res_next.status = ST_LARGE;
                    end
                    else if (ne_reg[c_calc])
                    begin
                        lg_next    = lg_calc;
                        cls_next   = c_calc;
                        slot_next  = head_reg[c_calc];
                        state_next = S_RM1;
                    end
                    else if (pages_ne_reg && (32'(lg_calc) <= LOG2_PAGE))
                    begin
                        lg_next    = lg_calc;
                        cls_next   = c_calc;
                        page_next  = fp_head_reg;
                        state_next = S_SP0;
                    end
                    else if (k_found)
                    begin
                        cls_next   = k_sel;
                        lg_next    = LG_W'(k_sel) + LG_W'(LOG2_SMALLEST);
                        slot_next  = head_reg[k_sel];
                        state_next = S_RM1;
                    end
                    else
                    begin
                        res_next.status = ST_NOMEM;
                    end
                end
                else
                begin
                    if (off_range)
                    begin
                        res_next.status = ST_RANGE;
                    end
                    else if (!off_align)
                    begin
                        res_next.status = ST_ALIGN;
                    end
                    else
                    begin
                        page_next  = PG_W'(off >> LOG2_PAGE);
                        slot_next  = SL_W'(off >> LOG2_SMALLEST);
                        state_next = S_FR1;
                    end
                end
            end
            // take the head page of the free-page list and size it
            S_SP0:
            begin
                pg_we        = 1'b1;
                pg_wd        = {lg_reg, nb_calc};
                fpn_ra       = page_reg;
                fp_last_next = (page_reg == fp_tail_reg);
                if (page_reg == fp_tail_reg)
                begin
                    pages_ne_next = 1'b0;
                end
                step_next  = SL_W'(1) << (lg_reg - LG_W'(LOG2_SMALLEST));
                slot_next  = pbase;
                cur_next   = pbase;
                pf_next    = 1'b1;
                state_next = S_SP1;
            end
            S_SP1:
            begin
                if (!fp_last_reg)
                begin
                    fp_head_next = fpn_val;
                end
                state_next = S_SPL;
            end
            // one slot of the page per cycle: mark it, link block starts in address order
            S_SPL:
            begin
                lst_we = 1'b1;
                lst_wa = cur_reg;
                lst_wd = blk_start;
                if (blk_start && (cur_reg != slot_reg))
                begin
                    prv_we = 1'b1;
                    prv_wa = cur_reg;
                    prv_wd = pslot_reg;
                    nxt_we = 1'b1;
                    nxt_wa = pslot_reg;
                    nxt_wd = cur_reg;
                end
                if (blk_start)
                begin
                    pslot_next = cur_reg;
                end
                cur_next = cur_reg + 1'b1;
                if (cur_reg[SPP_LOG-1:0] == '1)
                begin
                    head_next[cls_reg] = slot_reg;
                    tail_next[cls_reg] = blk_start ? cur_reg : pslot_reg;
                    ne_next[cls_reg]   = 1'b1;
                    state_next         = S_RM1;
                end
            end
            S_RM1:
            begin
                nxt_ra     = slot_reg;
                page_next  = PG_W'(slot_reg >> SPP_LOG);
                pg_ra      = PG_W'(slot_reg >> SPP_LOG);
                state_next = S_RM2;
            end
            // pop the list head and hand it out
            S_RM2:
            begin
                if (head_reg[cls_reg] == tail_reg[cls_reg])
                begin
                    ne_next[cls_reg] = 1'b0;
                end
                else
                begin
                    head_next[cls_reg] = nxt_rd;
                end
                lst_we = 1'b1;
                lst_wa = slot_reg;
                lst_wd = 1'b0;
                pg_we  = 1'b1;
                pg_wd  = {pg_lg, (pg_cnt != '0) ? pg_cnt - 1'b1 : pg_cnt};
                res_next.status          = ST_OK;
                res_next.granted_address = base_reg + (32'(slot_reg) << LOG2_SMALLEST);
                res_next.class_bytes     = 12'(32'd1 << lg_reg);
                res_next.page_fetched    = pf_reg;
                res_next.page_released   = 1'b0;
                res_next.page_number     = pf_reg ? 6'(page_reg) : '0;
                state_next               = S_DONE;
            end
            S_FR1:
            begin
                pg_ra      = page_reg;
                lst_ra     = slot_reg;
                state_next = S_FR2;
            end
            // reject a free of an unsplit page or a listed block, else push it at the list head
            S_FR2:
            begin
                if ((pg_lg == '0) || lst_rd)
                begin
                    res_next.status = ST_NOPAGE;
                    state_next      = S_DONE;
                end
                else
                begin
                    lg_next  = pg_lg;
                    cls_next = CLS_W'(pg_lg - LG_W'(LOG2_SMALLEST));
                    if (!ne_reg[CLS_W'(pg_lg - LG_W'(LOG2_SMALLEST))])
                    begin
                        tail_next[CLS_W'(pg_lg - LG_W'(LOG2_SMALLEST))] = slot_reg;
                        ne_next[CLS_W'(pg_lg - LG_W'(LOG2_SMALLEST))]   = 1'b1;
                    end
                    else
                    begin
                        prv_we = 1'b1;
                        prv_wa = head_reg[CLS_W'(pg_lg - LG_W'(LOG2_SMALLEST))];
                        prv_wd = slot_reg;
                        nxt_we = 1'b1;
                        nxt_wa = slot_reg;
                        nxt_wd = head_reg[CLS_W'(pg_lg - LG_W'(LOG2_SMALLEST))];
                    end
                    head_next[CLS_W'(pg_lg - LG_W'(LOG2_SMALLEST))] = slot_reg;
                    lst_we = 1'b1;
                    lst_wa = slot_reg;
                    lst_wd = 1'b1;
                    res_next.status      = ST_OK;
                    res_next.class_bytes = 12'(32'd1 << pg_lg);
                    if (cnt_inc == nb_fr)
                    begin
                        cur_next   = slot_reg;
                        state_next = S_WK1;
                    end
                    else
                    begin
                        pg_we      = 1'b1;
                        pg_wd      = {pg_lg, cnt_inc};
                        state_next = S_DONE;
                    end
                end
            end
            // page reclaim: walk the class list, unlinking this page's blocks
            S_WK1:
            begin
                nxt_ra = cur_reg;
                prv_ra = cur_reg;
                if (!ne_reg[cls_reg])
                begin
                    state_next = S_REL;
                end
                else
                begin
                    state_next = S_WK2;
                end
            end
            S_WK2:
            begin
                if (PG_W'(cur_reg >> SPP_LOG) == page_reg)
                begin
                    if ((cur_reg == head_reg[cls_reg]) && (cur_reg == tail_reg[cls_reg]))
                    begin
                        ne_next[cls_reg] = 1'b0;
                    end
                    else if (cur_reg == head_reg[cls_reg])
                    begin
                        head_next[cls_reg] = nxt_rd;
                    end
                    else if (cur_reg == tail_reg[cls_reg])
                    begin
                        tail_next[cls_reg] = prv_rd;
                    end
                    else
                    begin
                        nxt_we = 1'b1;
                        nxt_wa = prv_rd;
                        nxt_wd = nxt_rd;
                        prv_we = 1'b1;
                        prv_wa = nxt_rd;
                        prv_wd = prv_rd;
                    end
                    lst_we = 1'b1;
                    lst_wa = cur_reg;
                    lst_wd = 1'b0;
                end
                if (cur_reg == tail_reg[cls_reg])
                begin
                    state_next = S_REL;
                end
                else
                begin
                    cur_next   = nxt_rd;
                    state_next = S_WK1;
                end
            end
            // page back to the tail of the free-page list
            S_REL:
            begin
                pg_we = 1'b1;
                pg_wd = '0;
                if (pages_ne_reg)
                begin
                    fpn_we = 1'b1;
                    fpn_wa = fp_tail_reg;
                    fpn_wd = page_reg;
                end
                else
                begin
                    fp_head_next  = page_reg;
                    pages_ne_next = 1'b1;
                end
                fp_tail_next           = page_reg;
                res_next.status        = ST_OK;
                res_next.class_bytes   = 12'(32'd1 << lg_reg);
                res_next.page_released = 1'b1;
                res_next.page_number   = 6'(page_reg);
                state_next             = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // register write restarts the allocator
        if (cfg_wr)
        begin
            if (cfg_index == REG_BASE)
            begin
                base_next = cfg_data;
            end
            pages_n_next = np_new;
            for (int i = 0; i < NCLS; i++)
            begin
                head_next[i] = '0;
                tail_next[i] = '0;
            end
            ne_next       = '0;
            fp_head_next  = '0;
            fp_tail_next  = (np_new != '0) ? PG_W'(np_new - 1'b1) : '0;
            pages_ne_next = (np_new != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            base_reg     <= '0;
            pages_n_reg  <= '0;
            fp_head_reg  <= '0;
            fp_tail_reg  <= '0;
            pages_ne_reg <= 1'b0;
            ne_reg       <= '0;
            pg_vld_reg   <= '0;
            fpn_vld_reg  <= '0;
            res_reg      <= '0;
            for (int i = 0; i < NCLS; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            base_reg     <= base_next;
            pages_n_reg  <= pages_n_next;
            fp_head_reg  <= fp_head_next;
            fp_tail_reg  <= fp_tail_next;
            pages_ne_reg <= pages_ne_next;
            ne_reg       <= ne_next;
            res_reg      <= res_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            if (cfg_wr)
            begin
                pg_vld_reg  <= '0;
                fpn_vld_reg <= '0;
            end
            else
            begin
                if (pg_we)
                begin
                    pg_vld_reg[pg_wa] <= 1'b1;
                end
                if (fpn_we)
                begin
                    fpn_vld_reg[fpn_wa] <= 1'b1;
                end
            end
        end
    end

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        size_reg    <= size_next;
        addr_reg    <= addr_next;
        lg_reg      <= lg_next;
        cls_reg     <= cls_next;
        slot_reg    <= slot_next;
        cur_reg     <= cur_next;
        pslot_reg   <= pslot_next;
        step_reg    <= step_next;
        page_reg    <= page_next;
        pf_reg      <= pf_next;
        fp_last_reg <= fp_last_next;
        pg_vq_reg   <= pg_vld_reg[pg_ra];
        fpn_vq_reg  <= fpn_vld_reg[fpn_ra];
        fpn_aq_reg  <= fpn_ra;
    end

    pta_ram #(.DEPTH(NSLOT), .WIDTH(SL_W)) u_nxt (
        .clk   (clk),
        .we    (nxt_we),
        .waddr (nxt_wa),
        .wdata (nxt_wd),
        .raddr (nxt_ra),
        .rdata (nxt_rd)
    );

    pta_ram #(.DEPTH(NSLOT), .WIDTH(SL_W)) u_prv (
        .clk   (clk),
        .we    (prv_we),
        .waddr (prv_wa),
        .wdata (prv_wd),
        .raddr (prv_ra),
        .rdata (prv_rd)
    );

    pta_ram #(.DEPTH(NSLOT), .WIDTH(1)) u_lst (
        .clk   (clk),
        .we    (lst_we),
        .waddr (lst_wa),
        .wdata (lst_wd),
        .raddr (lst_ra),
        .rdata (lst_rd)
    );

    pta_ram #(.DEPTH(MAX_PAGES), .WIDTH(PGE_W)) u_pg (
        .clk   (clk),
        .we    (pg_we),
        .waddr (pg_wa),
        .wdata (pg_wd),
        .raddr (pg_ra),
        .rdata (pg_rd)
    );

    pta_ram #(.DEPTH(MAX_PAGES), .WIDTH(PG_W)) u_fpn (
        .clk   (clk),
        .we    (fpn_we),
        .waddr (fpn_wa),
        .wdata (fpn_wd),
        .raddr (fpn_ra),
        .rdata (fpn_rd)
    );

`ifndef ASSERT_OFF
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("block still busy after result");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ST_OK)) |-> ((granted_address == '0) && (class_bytes == '0)))
        else $error("error result carries an address or size");

    a_fetch_release: assert property (@(posedge clk) disable iff (!rst_n)
        (done && page_fetched) |-> !page_released)
        else $error("page fetched and released by one request");
`endif

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the power-of-two block allocator unit.
module tb_top;
    import pta_pkg::*;

    localparam int PAGE_BYTES = 4096;
    localparam int LG_MIN     = 3;
    localparam int LG_MAX     = 11;
    localparam int MAX_PAGES  = 64;
    localparam int CLASSES    = LG_MAX - LG_MIN + 1;
    localparam int SLOTS_PP   = PAGE_BYTES >> LG_MIN;
    localparam int SLOTS      = MAX_PAGES * SLOTS_PP;
    // watchdog: cycles with no request, result or register write
    localparam int STALL_LIMIT = 400000;

    localparam logic K_REQ = 1'b0;
    localparam logic K_REG = 1'b1;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        command;
    logic [11:0] request_size;
    logic [31:0] free_address;
    logic        done;
    logic [2:0]  status;
    logic [31:0] granted_address;
    logic [11:0] class_bytes;
    logic        page_fetched;
    logic        page_released;
    logic [5:0]  page_number;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [31:0] cfg_data;

    power_of_two_block_allocator_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .command         (command),
        .request_size    (request_size),
        .free_address    (free_address),
        .done            (done),
        .status          (status),
        .granted_address (granted_address),
        .class_bytes     (class_bytes),
        .page_fetched    (page_fetched),
        .page_released   (page_released),
        .page_number     (page_number),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // One row of the directed table: a request or a register write.
    // For a request, 'typed' means the result below is the expected one;
    // otherwise the allocator model supplies it.
    typedef struct packed {
        logic        kind;
        logic        cmd;
        logic [11:0] size;
        logic [31:0] addr;
        logic        typed;
        result_t     res;
    } stim_row_t;

    // ---------------------------------------------------------------
    // Allocator model state
    // ---------------------------------------------------------------
    logic [31:0] pool_base;
    logic [6:0]  pool_pages;
    int unsigned pg_lg [MAX_PAGES];
    int unsigned pg_free [MAX_PAGES];
    int unsigned blk_next [SLOTS];
    int unsigned blk_prev [SLOTS];
    bit          blk_listed [SLOTS];
    int unsigned cls_head [CLASSES];
    int unsigned cls_tail [CLASSES];
    bit          cls_any [CLASSES];
    int unsigned fp_next [MAX_PAGES];
    int unsigned fp_head;
    int unsigned fp_tail;
    bit          fp_any;

    result_t     pending_results[$];
    logic [31:0] live_blocks[$];
    stim_row_t   stim_table[$];
    int          errors;
    int          idle_pct;
    int          idle_cycles;

    function automatic int unsigned pages_used();
        return (pool_pages > MAX_PAGES) ? MAX_PAGES : int'(pool_pages);
    endfunction

    // Any register write empties every list and queues all pages in order
    task automatic pool_restart();
        int unsigned n;
        n = pages_used();
        for (int i = 0; i < MAX_PAGES; i++)
        begin
            pg_lg[i]   = 0;
            pg_free[i] = 0;
            fp_next[i] = (i + 1 < n) ? i + 1 : 0;
        end
        for (int i = 0; i < SLOTS; i++)
            blk_listed[i] = 0;
        for (int i = 0; i < CLASSES; i++)
        begin
            cls_any[i]  = 0;
            cls_head[i] = 0;
            cls_tail[i] = 0;
        end
        fp_head = 0;
        fp_tail = n ? n - 1 : 0;
        fp_any  = n != 0;
    endtask

    task automatic cls_append(int unsigned c, int unsigned s);
        if (!cls_any[c])
        begin
            cls_head[c] = s;
            cls_any[c]  = 1;
        end
        else
        begin
            blk_next[cls_tail[c]] = s;
            blk_prev[s] = cls_tail[c];
        end
        cls_tail[c]   = s;
        blk_listed[s] = 1;
    endtask

    task automatic cls_push(int unsigned c, int unsigned s);
        if (!cls_any[c])
        begin
            cls_tail[c] = s;
            cls_any[c]  = 1;
        end
        else
        begin
            blk_prev[cls_head[c]] = s;
            blk_next[s] = cls_head[c];
        end
        cls_head[c]   = s;
        blk_listed[s] = 1;
    endtask

    task automatic cls_remove(int unsigned c, int unsigned s);
        bit hd;
        bit tl;
        hd = s == cls_head[c];
        tl = s == cls_tail[c];
        if (hd && tl)
            cls_any[c] = 0;
        else if (hd)
            cls_head[c] = blk_next[s];
        else if (tl)
            cls_tail[c] = blk_prev[s];
        else
        begin
            blk_next[blk_prev[s]] = blk_next[s];
            blk_prev[blk_next[s]] = blk_prev[s];
        end
        blk_listed[s] = 0;
    endtask

    // Works out the single result of one request and advances the model
    task automatic model_request(input logic c, input logic [11:0] sz,
                                 input logic [31:0] a, output result_t r);
        int unsigned lg;
        int unsigned cl;
        int unsigned s;
        int unsigned p;
        int unsigned nb;
        int unsigned stp;
        int unsigned cur;
        int unsigned nxt;
        bit          found;
        bit          last;
        logic [31:0] off;
        r = '0;
        r.status = ST_OK;
        found = 0;
        s = 0;
        if (c == CMD_ALLOC)
        begin
            if (sz == 0)
                r.status = ST_ZERO;
            else if (sz > (1 << LG_MAX))
                r.status = ST_LARGE;
            else
            begin
                lg = LG_MIN;
                while ((1 << lg) < sz)
                    lg++;
                cl = lg - LG_MIN;
                if (cls_any[cl])
                begin
                    s = cls_head[cl];
                    found = 1;
                end
                else if (fp_any && (1 << lg) <= PAGE_BYTES)
                begin
                    // split the head page into blocks, in address order
                    p = fp_head;
                    if (p == fp_tail)
                        fp_any = 0;
                    else
                        fp_head = fp_next[p];
                    nb  = PAGE_BYTES >> lg;
                    stp = 1 << (lg - LG_MIN);
                    pg_lg[p]   = lg;
                    pg_free[p] = nb;
                    for (int i = 0; i < nb; i++)
                        cls_append(cl, p * SLOTS_PP + i * stp);
                    s = cls_head[cl];
                    found = 1;
                    r.page_fetched = 1;
                    r.page_number  = 6'(p);
                end
                else
                begin
                    for (int k = cl + 1; k < CLASSES && !found; k++)
                    begin
                        if (cls_any[k])
                        begin
                            cl = k;
                            lg = k + LG_MIN;
                            s  = cls_head[k];
                            found = 1;
                        end
                    end
                end
                if (found)
                begin
                    p = s / SLOTS_PP;
                    cls_remove(cl, s);
                    if (pg_free[p] > 0)
                        pg_free[p]--;
                    r.granted_address = pool_base + (s << LG_MIN);
                    r.class_bytes     = 12'(1 << lg);
                end
                else
                    r.status = ST_NOMEM;
            end
        end
        else
        begin
            off = a - pool_base;
            if (longint'(off) >= longint'(pages_used()) * PAGE_BYTES)
                r.status = ST_RANGE;
            else if (off[LG_MIN-1:0] != 0)
                r.status = ST_ALIGN;
            else
            begin
                p  = off / PAGE_BYTES;
                lg = pg_lg[p];
                s  = off >> LG_MIN;
                if (lg == 0 || blk_listed[s])
                    r.status = ST_NOPAGE;
                else
                begin
                    cl = lg - LG_MIN;
                    cls_push(cl, s);
                    pg_free[p]++;
                    r.class_bytes = 12'(1 << lg);
                    if (pg_free[p] == (PAGE_BYTES >> lg))
                    begin
                        // whole page free: pull its blocks off the class list
                        cur = cls_head[cl];
                        while (cls_any[cl])
                        begin
                            nxt  = blk_next[cur];
                            last = cur == cls_tail[cl];
                            if (cur / SLOTS_PP == p)
                                cls_remove(cl, cur);
                            if (last)
                                break;
                            cur = nxt;
                        end
                        pg_free[p] = 0;
                        pg_lg[p]   = 0;
                        if (fp_any)
                            fp_next[fp_tail] = p;
                        else
                        begin
                            fp_head = p;
                            fp_any  = 1;
                        end
                        fp_tail = p;
                        r.page_released = 1;
                        r.page_number   = 6'(p);
                    end
                end
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Clock, reset, watchdog, result checker
    // ---------------------------------------------------------------
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (done || (start && !busy) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Results cannot be held off: each done pulse is checked on the spot
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request outstanding");
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    errors++;
                end
                if (granted_address !== want.granted_address)
                begin
                    $error("granted_address: expected %h, got %h",
                           want.granted_address, granted_address);
                    errors++;
                end
                if (class_bytes !== want.class_bytes)
                begin
                    $error("class_bytes: expected %0d, got %0d",
                           want.class_bytes, class_bytes);
                    errors++;
                end
                if (page_fetched !== want.page_fetched)
                begin
                    $error("page_fetched: expected %0d, got %0d",
                           want.page_fetched, page_fetched);
                    errors++;
                end
                if (page_released !== want.page_released)
                begin
                    $error("page_released: expected %0d, got %0d",
                           want.page_released, page_released);
                    errors++;
                end
                if (page_number !== want.page_number)
                begin
                    $error("page_number: expected %0d, got %0d",
                           want.page_number, page_number);
                    errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------

    // Hold off until every result is back; every request answers, so a
    // short margin covers the last done pulse clearing.
    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_BASE)
            pool_base = val;
        else
            pool_pages = val[6:0];
        pool_restart();
        live_blocks.delete();
    endtask

    // Issues one request and leaves start high on return, so that a
    // following request goes out back to back unless an idle gap is drawn.
    task automatic issue_request(input logic c, input logic [11:0] sz,
                                 input logic [31:0] a, input logic typed,
                                 input result_t typed_res);
        result_t r;
        while (idle_pct != 0 && $urandom_range(99, 0) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        command      <= c;
        request_size <= sz;
        free_address <= a;
        do
            @(posedge clk);
        while (busy);
        model_request(c, sz, a, r);
        if (c == CMD_ALLOC && r.status == ST_OK)
            live_blocks.push_back(r.granted_address);
        pending_results.push_back(typed ? typed_res : r);
    endtask

    // One random request: mostly allocations of any class and frees of
    // live blocks, the rest noise, double frees and frees inside blocks.
    task automatic random_request();
        int          pick;
        int          idx;
        logic [11:0] sz;
        logic [31:0] a;
        pick = $urandom_range(99, 0);
        if (pick < 48 || live_blocks.size() == 0)
        begin
            sz = 12'($urandom_range(1 << $urandom_range(LG_MAX, LG_MIN), 1));
            issue_request(CMD_ALLOC, sz, $urandom, 1'b0, '0);
        end
        else if (pick < 88)
        begin
            idx = $urandom_range(live_blocks.size() - 1, 0);
            a = live_blocks[idx];
            live_blocks.delete(idx);
            issue_request(CMD_FREE, 12'($urandom), a, 1'b0, '0);
        end
        else if (pick < 92)
            issue_request(CMD_ALLOC, 12'($urandom), $urandom, 1'b0, '0);
        else if (pick < 95)
            issue_request(CMD_FREE, 12'($urandom), $urandom, 1'b0, '0);
        else
        begin
            // near a live block: double free, inside or misaligned
            a = live_blocks[$urandom_range(live_blocks.size() - 1, 0)];
            a = a + ($urandom_range(7, 0) << $urandom_range(3, 0)) - 8;
            issue_request(CMD_FREE, 12'($urandom), a, 1'b0, '0);
        end
    endtask

    task automatic add_req(input logic c, input logic [11:0] sz, input logic [31:0] a);
        stim_table.push_back('{K_REQ, c, sz, a, 1'b0, result_t'('0)});
    endtask

    task automatic add_typed(input logic c, input logic [11:0] sz, input logic [31:0] a,
                             input status_t st);
        result_t r;
        r = '0;
        r.status = st;
        stim_table.push_back('{K_REQ, c, sz, a, 1'b1, r});
    endtask

    task automatic add_reg(input logic idx, input logic [31:0] val);
        stim_table.push_back('{K_REG, 1'b0, 12'd0, val, 1'b0, result_t'('0)});
        stim_table[$].cmd = idx;
    endtask

    initial
    begin
        logic [31:0] base_pick [6];
        logic [6:0]  pages_pick [6];
        int          pct_pick [6];
        stim_row_t   row;

        rst_n        = 1'b0;
        start        = 1'b0;
        command      = CMD_ALLOC;
        request_size = '0;
        free_address = '0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_BASE;
        cfg_data     = '0;
        errors       = 0;
        idle_pct     = 0;
        idle_cycles  = 0;
        pool_base    = '0;
        pool_pages   = '0;
        pool_restart();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. The region starts just below 2^32, so the
        // second page sits at address zero and the third past the wrap.
        add_typed(CMD_ALLOC, 12'd8, 32'h0, ST_NOMEM);     // no pages after reset
        add_typed(CMD_FREE, 12'd0, 32'h0, ST_RANGE);
        add_reg(REG_BASE, 32'hFFFF_F000);
        add_reg(REG_PAGES, 32'd3);
        add_typed(CMD_ALLOC, 12'd0, 32'h0, ST_ZERO);
        add_typed(CMD_ALLOC, 12'd4095, 32'hFFFF_FFFF, ST_LARGE);
        add_typed(CMD_ALLOC, 12'd2049, 32'h0, ST_LARGE);
        add_req(CMD_ALLOC, 12'd2048, 32'h0);              // splits page 0
        add_req(CMD_ALLOC, 12'd1, 32'h0);                 // splits page 1, address zero
        add_req(CMD_ALLOC, 12'd8, 32'h0);
        add_typed(CMD_FREE, 12'hFFF, 32'hFFFF_F001, ST_ALIGN);
        add_typed(CMD_FREE, 12'd0, 32'h0000_2000, ST_RANGE);
        add_typed(CMD_FREE, 12'd0, 32'hFFFF_EFF8, ST_RANGE);
        add_typed(CMD_FREE, 12'd0, 32'h0000_1000, ST_NOPAGE); // page never split
        add_req(CMD_FREE, 12'd0, 32'h0000_0008);
        add_typed(CMD_FREE, 12'd0, 32'h0000_0008, ST_NOPAGE); // double free
        add_req(CMD_FREE, 12'd0, 32'h0000_0000);          // whole page back
        add_req(CMD_FREE, 12'd0, 32'hFFFF_F008);          // inside a 2 KiB block
        for (int i = 0; i < 7; i++)
            add_req(CMD_ALLOC, 12'd2048, 32'h0);          // runs out of memory
        add_req(CMD_ALLOC, 12'd16, 32'h0);

        foreach (stim_table[i])
        begin
            row = stim_table[i];
            if (row.kind == K_REG)
                write_reg(row.cmd, row.addr);
            else
                issue_request(row.cmd, row.size, row.addr, row.typed, row.res);
        end

        // Random phases over several region settings, extremes included;
        // a page count above the maximum saturates.
        base_pick  = '{32'h0, 32'hFFFF_FFFF, $urandom, 32'h8000_0000, $urandom, 32'h0};
        pages_pick = '{7'd64, 7'd127, 7'd1, 7'd0, 7'($urandom_range(64, 1)), 7'd4};
        pct_pick   = '{0, 80, 80, 29, 0, 80};
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(REG_BASE, base_pick[ph]);
            write_reg(REG_PAGES, ($urandom & ~32'h7F) | pages_pick[ph]);
            idle_pct = pct_pick[ph];
            for (int n = 0; n < 110; n++)
            begin
                if (n == 55)
                    drain();
                random_request();
            end
        end

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
